FILE: rtl/gbm_monte_carlo_paths_defines.svh
// Assertion helpers for the checker file.
`ifndef GBM_MONTE_CARLO_PATHS_DEFINES_SVH
`define GBM_MONTE_CARLO_PATHS_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define GMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gmc_pkg.sv
`timescale 1ns / 1ps
package gmc_pkg;

  localparam int PRICE_W   = 32;
  localparam int SHOCK_W   = 16;
  localparam int DRIFT_W   = 32;
  localparam int VOL_W     = 30;
  localparam int CNT_W     = 16;
  localparam int X_W       = 36;
  localparam int SUM_W     = 48;
  localparam int SQ_W      = 64;
  localparam int E_W       = 52;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int N_TERMS   = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_PRICE = 3'd0,
    REG_DRIFT       = 3'd1,
    REG_VOL         = 3'd2,
    REG_STEPS       = 3'd3,
    REG_PATHS       = 3'd4
  } cfg_reg_e;

  typedef logic signed [X_W-1:0] xval_t;

  typedef struct packed {
    logic [PRICE_W-1:0]        start_price;
    logic signed [DRIFT_W-1:0] drift_per_step;
    logic [VOL_W-1:0]          vol_per_step;
    logic [CNT_W-1:0]          steps_per_path;
    logic [CNT_W-1:0]          path_total;
  } cfg_t;

  // floor(2^32 / n) for the Taylor term divisors
  function automatic logic [32:0] recip(input logic [3:0] n);
    logic [32:0] r;
    unique case (n)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/gmc_ifs.sv
`timescale 1ns / 1ps
interface gmc_shock_if;
  import gmc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SHOCK_W-1:0] shock;
  modport source (output valid, output shock, input ready);
  modport sink   (input valid, input shock, output ready);
endinterface

interface gmc_result_if;
  import gmc_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] final_price;
  logic [CNT_W-1:0]   path_number;
  logic [PRICE_W-1:0] mean_price;
  logic [PRICE_W-1:0] std_dev;
  logic               stats_valid;
  modport source (output valid, output final_price, output path_number,
                  output mean_price, output std_dev, output stats_valid, input ready);
  modport sink   (input valid, input final_price, input path_number,
                  input mean_price, input std_dev, input stats_valid, output ready);
endinterface

interface gmc_cfg_if;
  import gmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gmc_front.sv
`timescale 1ns / 1ps
module gmc_front (
  input  gmc_pkg::cfg_t  cfg_i,
  gmc_shock_if.sink      shock_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output gmc_pkg::xval_t q_data_o
);
  import gmc_pkg::*;

  logic signed [46:0] prod;
  logic signed [46:0] prod_rnd;
  logic signed [X_W-1:0] vz;
  logic signed [X_W-1:0] drift;

  // x = drift + round(vol * z / 2^12), half up
  assign prod     = $signed({1'b0, cfg_i.vol_per_step}) * shock_i.shock;
  assign prod_rnd = prod + 47'sd2048;
  assign vz       = $signed({prod_rnd[46], prod_rnd[46:12]});
  assign drift    = $signed({{(X_W-DRIFT_W){cfg_i.drift_per_step[DRIFT_W-1]}},
                             cfg_i.drift_per_step});

  assign shock_i.ready = !q_full_i;
  assign q_push_o      = shock_i.valid && !q_full_i;
  assign q_data_o      = vz + drift;

endmodule

FILE: rtl/gmc_fifo.sv
`timescale 1ns / 1ps
module gmc_fifo #(
  parameter int W     = 36,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        mem_q[wr_q] <= data_i;
        wr_q        <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/gmc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module gmc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  logic [63:0] quo_q;
  logic [16:0] rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [17:0] trial;
  logic        ge;

  assign trial      = {rem_q, quo_q[63]};
  assign ge         = trial >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/gmc_back.sv
`timescale 1ns / 1ps
module gmc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gmc_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  gmc_pkg::xval_t q_data_i,
  output logic           q_pop_o,
  gmc_result_if.source   result_o
);
  import gmc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KDIV, ST_KFIX, ST_TMUL, ST_TREC, ST_TCOR, ST_ESHIFT,
    ST_MLO, ST_MHI, ST_MCMB, ST_SQ, ST_ACC, ST_MEANGO, ST_MEANW,
    ST_MSQGO, ST_MSQW, ST_M2, ST_VAR, ST_SQRT, ST_EMIT
  } state_e;

  state_e state_q;

  // exp datapath
  logic              neg_q;
  logic [34:0]       rem_q;
  logic [4:0]        kq_q;
  logic [2:0]        bit_q;
  logic signed [6:0] k_q;
  logic [29:0]       r_q;
  logic [30:0]       term_q;
  logic [31:0]       sum_q;
  logic [3:0]        n_q;
  logic [60:0]       prod_q;
  logic [29:0]       p_q;
  logic [62:0]       pr_q;
  logic [E_W-1:0]    e_q;
  // price update
  logic [PRICE_W-1:0] base_q, cur_q, price_q;
  logic [63:0]        lo_q;
  logic [51:0]        hi_q;
  logic [CNT_W-1:0]   step_q, path_q, idx_q;
  // statistics
  logic [SUM_W-1:0]   psum_q;
  logic [SQ_W-1:0]    ssum_q, sq_q, msq_q, var_q, sqv_q, sres_q, sbit_q;
  logic [16:0]        nd_q;
  logic               stats_q;
  logic [PRICE_W-1:0] mean_q;
  // result register
  logic               out_valid_q;
  logic [PRICE_W-1:0] out_price_q, out_mean_q, out_std_q;
  logic [CNT_W-1:0]   out_path_q;
  logic               out_stats_q;

  logic [34:0]       lsh, xabs;
  logic [29:0]       qe, remv, qf;
  logic [33:0]       qn;
  logic signed [6:0] kc;
  logic [5:0]        sh;
  logic [63:0]       rnd;
  logic [E_W-1:0]    e_new;
  logic [64:0]       lo_r;
  logic [35:0]       res;
  logic [PRICE_W-1:0] price_new;
  logic [CNT_W-1:0]  stepn, pathn;
  logic              pend, pstats;
  logic [64:0]       stot;
  logic [SUM_W-1:0]  psum_new;
  logic [SQ_W-1:0]   strial;
  logic              div_start, div_done;
  logic [63:0]       div_a, div_quo;
  logic              emit_ok;

  always_comb begin
    xabs = q_data_i[X_W-1] ? 35'(-q_data_i) : q_data_i[34:0];
    lsh  = 35'(LN2_Q30) << bit_q;
    // Taylor divide by n: reciprocal estimate, off by at most one
    qe   = pr_q[61:32];
    qn   = 34'(qe) * 34'(n_q);
    remv = p_q - qn[29:0];
    qf   = (remv >= 30'(n_q)) ? qe + 30'd1 : qe;
    // scale by 2^k
    if (k_q > 7'sd20) begin
      kc = 7'sd20;
    end else if (k_q < -7'sd60) begin
      kc = -7'sd60;
    end else begin
      kc = k_q;
    end
    sh  = 6'(-kc);
    rnd = {32'd0, sum_q} + (64'd1 << (sh - 6'd1));
    if (!kc[6]) begin
      e_new = {20'd0, sum_q} << kc[4:0];
    end else begin
      e_new = 52'(rnd >> sh);
    end
    // price * e, rounded to nearest, saturated
    lo_r = ({1'b0, lo_q} + 65'd536870912) >> 30;
    res  = 36'({hi_q[31:0], 2'b00}) + 36'(lo_r[34:0]);
    price_new = ((|hi_q[51:32]) || (|res[35:32])) ? '1 : res[31:0];
    stepn  = step_q + 16'd1;
    pend   = (stepn == '0) || (stepn >= cfg_i.steps_per_path);
    pathn  = path_q + 16'd1;
    pstats = (pathn == '0) || (pathn >= cfg_i.path_total);
    psum_new = psum_q + SUM_W'(price_q);
    stot   = {1'b0, ssum_q} + {1'b0, sq_q};
    strial = sres_q + sbit_q;
    div_a  = (state_q == ST_MEANGO) ? 64'(psum_q) + 64'(nd_q >> 1) : ssum_q;
  end

  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign div_start = (state_q == ST_MEANGO) || (state_q == ST_MSQGO);
  assign emit_ok   = !out_valid_q || result_o.ready;

  gmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (nd_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      path_q      <= '0;
      psum_q      <= '0;
      ssum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_EMIT the emit arm alone decides the valid flag
      if (out_valid_q && result_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            neg_q   <= q_data_i[X_W-1];
            rem_q   <= xabs;
            kq_q    <= '0;
            bit_q   <= 3'd4;
            state_q <= ST_KDIV;
          end
        end
        ST_KDIV: begin
          if (rem_q >= lsh) begin
            rem_q       <= rem_q - lsh;
            kq_q[bit_q] <= 1'b1;
          end
          if (bit_q == 3'd0) begin
            state_q <= ST_KFIX;
          end
          bit_q <= bit_q - 3'd1;
        end
        ST_KFIX: begin
          // floor division for negative x
          if (!neg_q) begin
            k_q <= $signed({2'b00, kq_q});
            r_q <= rem_q[29:0];
          end else if (rem_q != '0) begin
            k_q <= -$signed({2'b00, kq_q}) - 7'sd1;
            r_q <= LN2_Q30 - rem_q[29:0];
          end else begin
            k_q <= -$signed({2'b00, kq_q});
            r_q <= '0;
          end
          term_q  <= 31'h4000_0000;
          sum_q   <= 32'h4000_0000;
          n_q     <= 4'd1;
          state_q <= ST_TMUL;
        end
        ST_TMUL: begin
          prod_q  <= 61'(term_q) * 61'(r_q);
          state_q <= ST_TREC;
        end
        ST_TREC: begin
          p_q     <= prod_q[59:30];
          pr_q    <= 63'(prod_q[59:30]) * 63'(recip(n_q));
          state_q <= ST_TCOR;
        end
        ST_TCOR: begin
          term_q <= {1'b0, qf};
          sum_q  <= sum_q + 32'(qf);
          n_q    <= n_q + 4'd1;
          state_q <= (n_q == 4'(N_TERMS)) ? ST_ESHIFT : ST_TMUL;
        end
        ST_ESHIFT: begin
          e_q     <= e_new;
          base_q  <= (step_q == '0) ? cfg_i.start_price : cur_q;
          state_q <= ST_MLO;
        end
        ST_MLO: begin
          lo_q    <= 64'(base_q) * 64'(e_q[31:0]);
          state_q <= ST_MHI;
        end
        ST_MHI: begin
          hi_q    <= 52'(base_q) * 52'(e_q[51:32]);
          state_q <= ST_MCMB;
        end
        ST_MCMB: begin
          if (pend) begin
            step_q  <= '0;
            price_q <= price_new;
            cur_q   <= cfg_i.start_price;
            state_q <= ST_SQ;
          end else begin
            step_q  <= stepn;
            cur_q   <= price_new;
            state_q <= ST_IDLE;
          end
        end
        ST_SQ: begin
          sq_q    <= 64'(price_q) * 64'(price_q);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          psum_q  <= psum_new;
          ssum_q  <= stot[64] ? '1 : stot[63:0];
          idx_q   <= path_q;
          nd_q    <= 17'(path_q) + 17'd1;
          stats_q <= pstats;
          path_q  <= pstats ? '0 : pathn;
          state_q <= pstats ? ST_MEANGO : ST_EMIT;
        end
        ST_MEANGO: state_q <= ST_MEANW;
        ST_MEANW: begin
          if (div_done) begin
            mean_q  <= (|div_quo[63:32]) ? '1 : div_quo[31:0];
            state_q <= ST_MSQGO;
          end
        end
        ST_MSQGO: state_q <= ST_MSQW;
        ST_MSQW: begin
          if (div_done) begin
            msq_q   <= div_quo;
            state_q <= ST_M2;
          end
        end
        ST_M2: begin
          var_q   <= 64'(mean_q) * 64'(mean_q);
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          sqv_q   <= (msq_q > var_q) ? msq_q - var_q : '0;
          sres_q  <= '0;
          sbit_q  <= 64'h4000_0000_0000_0000;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          // digit-by-digit integer square root, two bits per cycle
          if (sqv_q >= strial) begin
            sqv_q  <= sqv_q - strial;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 64'd1) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_price_q <= price_q;
            out_path_q  <= idx_q;
            out_mean_q  <= stats_q ? mean_q : '0;
            out_std_q   <= stats_q ? sres_q[31:0] : '0;
            out_stats_q <= stats_q;
            if (stats_q) begin
              psum_q <= '0;
              ssum_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.final_price = out_price_q;
  assign result_o.path_number = out_path_q;
  assign result_o.mean_price  = out_mean_q;
  assign result_o.std_dev     = out_std_q;
  assign result_o.stats_valid = out_stats_q;

endmodule

FILE: rtl/gbm_monte_carlo_paths.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields                                              Accepted when
// shock_i   in   shock                                               valid && ready
// result_o  out  final_price path_number mean_price std_dev stats    valid && ready
// cfg_i     in   index data (registers 0..4)                         valid && ready
//
// Each shock passes through the back end: a restoring division splits off k, then the
// 12-term exp series runs, each term a multiply, a reciprocal multiply and a correction.
// A path end adds squaring and accumulation; a batch end adds two 64-step divides
// and a square root. The front queues shocks while the back works.
// A result waiting in the output register stalls the back end only at its next
// result. rst_ni clears counters, sums and handshakes; cfg_i is always ready.
module gbm_monte_carlo_paths #(
  parameter int QueueDepth = gmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gmc_shock_if.sink    shock_i,
  gmc_result_if.source result_o,
  gmc_cfg_if.sink      cfg_i
);
  import gmc_pkg::*;

  cfg_t  cfg_q;
  logic  q_full, q_push, q_pop, q_empty;
  xval_t q_wdata;
  logic [X_W-1:0] q_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_price    <= 32'd6553600;
      cfg_q.drift_per_step <= '0;
      cfg_q.vol_per_step   <= '0;
      cfg_q.steps_per_path <= 16'd252;
      cfg_q.path_total     <= 16'd1000;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_START_PRICE: cfg_q.start_price    <= cfg_i.data;
        REG_DRIFT:       cfg_q.drift_per_step <= $signed(cfg_i.data);
        REG_VOL:         cfg_q.vol_per_step   <= cfg_i.data[VOL_W-1:0];
        REG_STEPS:       cfg_q.steps_per_path <= cfg_i.data[CNT_W-1:0];
        REG_PATHS:       cfg_q.path_total     <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  gmc_front u_front (
    .cfg_i    (cfg_q),
    .shock_i  (shock_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  gmc_fifo #(
    .W     (X_W),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  gmc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  ($signed(q_rdata)),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

FILE: rtl/gmc_checker.sv
`timescale 1ns / 1ps
`include "gbm_monte_carlo_paths_defines.svh"
module gmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] final_price_i,
  input logic [15:0] path_number_i,
  input logic [31:0] mean_price_i,
  input logic [31:0] std_dev_i,
  input logic        stats_valid_i
);

  `GMC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `GMC_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(final_price_i) && $stable(path_number_i), "result changed while stalled")
  `GMC_ASSERT(a_stats_zero, clk_i, rst_ni, out_valid_i && !stats_valid_i |-> mean_price_i == 32'd0 && std_dev_i == 32'd0, "statistics set on a mid-batch item")
  `GMC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind gbm_monte_carlo_paths gmc_checker u_gmc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .final_price_i (result_o.final_price),
  .path_number_i (result_o.path_number),
  .mean_price_i  (result_o.mean_price),
  .std_dev_i     (result_o.std_dev),
  .stats_valid_i (result_o.stats_valid)
);
